[src/lcsq_pkg.sv]
package lcsq_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int ELAPSED_W = 10;
    localparam int TIMER_W   = 10;
    localparam int WEIGHT_W  = 41;
    localparam int FRAC_BITS = 16;
    localparam int CPK_W     = 24;

    localparam int DIV_STEPS = WEIGHT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_TARE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CPK     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [SAMPLE_W-1:0] TARE_RESET    = '0;
    localparam logic [CPK_W-1:0]    CPK_RESET     = 24'd1;
    localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 10'd500;

    localparam logic [TIMER_W-1:0]  TIMER_MAX     = '1;

    // Bus glitch patterns: all zeros and all ones.
    localparam logic [SAMPLE_W-1:0] GLITCH_ZERO = '0;
    localparam logic [SAMPLE_W-1:0] GLITCH_ONES = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] tare;
        logic [CPK_W-1:0]    cpk;
        logic [TIMER_W-1:0]  timeout;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic step_div;
        logic load_out;
    } cmd_t;

endpackage

[src/lcsq_regs.sv]
module lcsq_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcsq_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcsq_pkg::DATA_W-1:0]   pwdata,
    output logic [lcsq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output lcsq_pkg::cfg_t                cfg
);

    logic [lcsq_pkg::SAMPLE_W-1:0] tare_reg;
    logic [lcsq_pkg::CPK_W-1:0]    cpk_reg;
    logic [lcsq_pkg::TIMER_W-1:0]  timeout_reg;
    logic [lcsq_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[lcsq_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg    <= lcsq_pkg::TARE_RESET;
            cpk_reg     <= lcsq_pkg::CPK_RESET;
            timeout_reg <= lcsq_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            case (idx)
                lcsq_pkg::REG_TARE:    tare_reg    <= pwdata[lcsq_pkg::SAMPLE_W-1:0];
                lcsq_pkg::REG_CPK:     cpk_reg     <= pwdata[lcsq_pkg::CPK_W-1:0];
                lcsq_pkg::REG_TIMEOUT: timeout_reg <= pwdata[lcsq_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            lcsq_pkg::REG_TARE:
                prdata = {{(lcsq_pkg::DATA_W-lcsq_pkg::SAMPLE_W){1'b0}}, tare_reg};
            lcsq_pkg::REG_CPK:
                prdata = {{(lcsq_pkg::DATA_W-lcsq_pkg::CPK_W){1'b0}}, cpk_reg};
            lcsq_pkg::REG_TIMEOUT:
                prdata = {{(lcsq_pkg::DATA_W-lcsq_pkg::TIMER_W){1'b0}}, timeout_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.tare    = tare_reg;
    assign cfg.cpk     = cpk_reg;
    assign cfg.timeout = timeout_reg;

endmodule

[src/lcsq_ctrl.sv]
module lcsq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output lcsq_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [lcsq_pkg::CNT_W-1:0] LAST_STEP =
        lcsq_pkg::CNT_W'(lcsq_pkg::DIV_STEPS - 1);

    logic [1:0]                 state_reg, state_next;
    logic [lcsq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.load_div = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.step_div = 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // The result register is free, or its transfer completes now.
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[src/lcsq_datapath.sv]
module lcsq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lcsq_pkg::cmd_t                  cmd,
    input  lcsq_pkg::cfg_t                  cfg,
    input  logic                            s_data_ready,
    input  logic signed [lcsq_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [lcsq_pkg::ELAPSED_W-1:0]  s_elapsed_ms,
    output logic [lcsq_pkg::WEIGHT_W-1:0]   m_weight_q16,
    output logic signed [lcsq_pkg::SAMPLE_W-1:0] m_held_raw,
    output logic                            m_is_new,
    output logic                            m_reinit_request
);

    localparam int SW = lcsq_pkg::SAMPLE_W;
    localparam int WW = lcsq_pkg::WEIGHT_W;
    localparam int DW = lcsq_pkg::CPK_W;
    localparam int TW = lcsq_pkg::TIMER_W;

    // Poll state.
    logic [SW-1:0] held_reg, held_next;
    logic [TW-1:0] timer_reg, timer_next;
    logic          pend_reg, pend_next;
    logic          is_new_reg, is_new_next;
    logic          reinit_reg;

    // Divider.
    logic [DW-1:0] rem_reg, rem_next;
    logic [WW-1:0] quo_reg, quo_next;

    // Result register.
    logic [WW-1:0] weight_out_reg;
    logic [SW-1:0] held_out_reg;
    logic          new_out_reg;
    logic          reinit_out_reg;

    logic [TW:0]   timer_sum;
    logic [TW-1:0] timer_sat;
    logic [SW:0]   diff;
    logic [SW:0]   mag_wide;
    logic [DW:0]   shifted;
    logic [DW+1:0] trial;

    always_comb begin
        held_next   = held_reg;
        is_new_next = 1'b0;
        timer_sum   = {1'b0, timer_reg} + {1'b0, s_elapsed_ms};
        timer_sat   = timer_sum[TW] ? lcsq_pkg::TIMER_MAX : timer_sum[TW-1:0];
        pend_next   = 1'b0;
        if (s_data_ready) begin
            timer_next = '0;
            if (s_sample != lcsq_pkg::GLITCH_ZERO && s_sample != lcsq_pkg::GLITCH_ONES) begin
                held_next   = s_sample;
                is_new_next = 1'b1;
            end
        end else begin
            // A reinit poll drops the time that passed before it.
            timer_next = pend_reg ? '0 : timer_sat;
            pend_next  = timer_next > cfg.timeout;
        end
    end

    always_comb begin
        diff     = {held_reg[SW-1], held_reg} - {cfg.tare[SW-1], cfg.tare};
        mag_wide = diff[SW] ? (~diff + 1'b1) : diff;
    end

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {rem_reg, quo_reg[WW-1]};
        trial   = {1'b0, shifted} - {2'b00, cfg.cpk};
        if (!trial[DW+1]) begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[WW-2:0], 1'b1};
        end else begin
            rem_next = shifted[DW-1:0];
            quo_next = {quo_reg[WW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            timer_reg <= '0;
            pend_reg  <= 1'b0;
        end else if (cmd.accept) begin
            held_reg  <= held_next;
            timer_reg <= timer_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_new_reg <= is_new_next;
            reinit_reg <= pend_reg;
        end
        if (cmd.load_div) begin
            rem_reg <= '0;
            quo_reg <= {1'b0, mag_wide[SW-1:0], {lcsq_pkg::FRAC_BITS{1'b0}}};
        end else if (cmd.step_div) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.load_out) begin
            weight_out_reg <= quo_reg;
            held_out_reg   <= held_reg;
            new_out_reg    <= is_new_reg;
            reinit_out_reg <= reinit_reg;
        end
    end

    assign m_weight_q16     = weight_out_reg;
    assign m_held_raw       = held_out_reg;
    assign m_is_new         = new_out_reg;
    assign m_reinit_request = reinit_out_reg;

endmodule

[src/load_cell_sample_qualifier_unit.sv]
// Load-cell poll qualifier. Each transfer on the s_ side is one converter poll and yields
// exactly one transfer on the m_ side: the held sample, whether this poll took a new one,
// whether the converter must be reinitialized, and |held - tare| * 2^16 / counts_per_kg
// truncated (all ones when counts_per_kg is 0). The poll state is updated at the edge that
// accepts the poll. Then one step forms the tared magnitude and loads the divider, 41 passes
// go through the shift-and-subtract divider, and a last step loads the result register once
// it is free or its transfer completes. A poll holds the block until its result is loaded,
// so polls do not overlap; s_ready is high only while no poll is in flight, and the next
// poll may be taken while the previous result still waits for m_ready. Registers on the
// APB port: tare_offset at 0x0, counts_per_kg at 0x4, stall_timeout_ms at 0x8; write them
// only while no poll is in flight.
module load_cell_sample_qualifier_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcsq_pkg::ADDR_W-1:0]         paddr,
    input  logic [lcsq_pkg::DATA_W-1:0]         pwdata,
    output logic [lcsq_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_data_ready,
    input  logic signed [lcsq_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [lcsq_pkg::ELAPSED_W-1:0]      s_elapsed_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lcsq_pkg::WEIGHT_W-1:0]       m_weight_q16,
    output logic signed [lcsq_pkg::SAMPLE_W-1:0] m_held_raw,
    output logic                                m_is_new,
    output logic                                m_reinit_request
);

    lcsq_pkg::cfg_t cfg;
    lcsq_pkg::cmd_t cmd;

    lcsq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lcsq_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg              (cfg),
        .s_data_ready     (s_data_ready),
        .s_sample         (s_sample),
        .s_elapsed_ms     (s_elapsed_ms),
        .m_weight_q16     (m_weight_q16),
        .m_held_raw       (m_held_raw),
        .m_is_new         (m_is_new),
        .m_reinit_request (m_reinit_request)
    );

    // A poll in flight blocks the next one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("poll accepted while another poll was in flight");

    // A newly taken sample is never one of the glitch patterns.
    a_new_not_glitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_new) |->
            (m_held_raw != lcsq_pkg::GLITCH_ZERO && m_held_raw != lcsq_pkg::GLITCH_ONES))
        else $error("glitch sample reported as new");

    // A poll result cannot appear in the cycle right after a poll is taken.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result presented before the divider could finish");

endmodule
